/* design/sha1s_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and round functions of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  localparam int unsigned BLK_WORDS    = 16;
  localparam int unsigned BLK_BITS     = 32 * BLK_WORDS;
  localparam int unsigned ROUNDS       = 80;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned Q_DEPTH      = 2;
  localparam int unsigned Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [2:0] MAX_BYTES = 3'd4;
  localparam logic [2:0] LAST_IDX  = 3'd4;
  localparam logic [2:0] LAST_LEN  = 3'd7;
  localparam logic [6:0] LAST_RND  = 7'd79;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [BLK_BITS-1:0] block;
    logic                last_blk;
  } blk_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DATA,
    F_PAD,
    F_ZERO,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD,
    C_OUT
  } core_state_t;

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0:    h = H0;
      3'd1:    h = H1;
      3'd2:    h = H2;
      3'd3:    h = H3;
      default: h = H4;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20)      f = (b & c) | (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20)      k = K0;
    else if (t < 7'd40) k = K1;
    else if (t < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

endpackage

/* design/sha1s_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_front
// Takes message words, packs their bytes into 64-byte blocks, appends the
// padding and bit length on the final word, and pushes full blocks to the queue.
// ----------------------------------------------------------------------------
module sha1s_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha1s_pkg::in_item_t   in_item,
  input  sha1s_pkg::q_stat_t    q_stat,
  output logic                  push,
  output sha1s_pkg::blk_entry_t push_entry
);

  sha1s_pkg::front_state_t state_r, state_nxt;

  logic [31:0]                    hold_word_r;
  logic [2:0]                     cnt_r;
  logic [1:0]                     bidx_r;
  logic                           end_r;
  logic [5:0]                     fill_r;
  logic [63:0]                    total_r;
  logic [2:0]                     len_idx_r;
  logic [sha1s_pkg::BLK_BITS-1:0] blk_r;

  logic                           accept;
  logic [2:0]                     cnt_sat;
  logic [7:0]                     byte_val;
  logic                           byte_wr;
  logic                           wr_ok;
  logic [5:0]                     fill_inc;
  logic [63:0]                    bit_len;
  logic [sha1s_pkg::BLK_BITS-1:0] blk_wr;

  assign accept   = in_valid && in_ready;
  assign cnt_sat  = (in_item.byte_count > sha1s_pkg::MAX_BYTES) ? sha1s_pkg::MAX_BYTES
                                                                 : in_item.byte_count;
  assign fill_inc = fill_r + 6'd1;
  assign bit_len  = {total_r[60:0], 3'b000};
  // hold the byte that completes a block until the queue has room
  assign wr_ok    = byte_wr && !(fill_r == sha1s_pkg::LAST_POS && q_stat.full);

  // byte source and handshake
  always_comb begin
    in_ready = 1'b0;
    byte_wr  = 1'b0;
    byte_val = 8'h00;
    unique case (state_r)
      sha1s_pkg::F_IDLE: begin
        in_ready = 1'b1;
      end
      sha1s_pkg::F_DATA: begin
        byte_wr  = 1'b1;
        byte_val = hold_word_r[{~bidx_r, 3'b000} +: 8];
      end
      sha1s_pkg::F_PAD: begin
        byte_wr  = 1'b1;
        byte_val = sha1s_pkg::PAD_BYTE;
      end
      sha1s_pkg::F_ZERO: begin
        byte_wr  = 1'b1;
      end
      sha1s_pkg::F_LEN: begin
        byte_wr  = 1'b1;
        byte_val = bit_len[{~len_idx_r, 3'b000} +: 8];
      end
      default: begin
        byte_wr  = 1'b0;
      end
    endcase
  end

  always_comb begin
    blk_wr = blk_r;
    blk_wr[{~fill_r, 3'b000} +: 8] = byte_val;
  end

  assign push                = wr_ok && (fill_r == sha1s_pkg::LAST_POS);
  assign push_entry.block    = blk_wr;
  assign push_entry.last_blk = (state_r == sha1s_pkg::F_LEN);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1s_pkg::F_IDLE: begin
        if (accept) begin
          if (cnt_sat != 3'd0)             state_nxt = sha1s_pkg::F_DATA;
          else if (in_item.end_of_message) state_nxt = sha1s_pkg::F_PAD;
        end
      end
      sha1s_pkg::F_DATA: begin
        if (wr_ok && ({1'b0, bidx_r} + 3'd1 == cnt_r)) begin
          state_nxt = end_r ? sha1s_pkg::F_PAD : sha1s_pkg::F_IDLE;
        end
      end
      sha1s_pkg::F_PAD, sha1s_pkg::F_ZERO: begin
        if (wr_ok) begin
          state_nxt = (fill_inc == sha1s_pkg::LEN_POS) ? sha1s_pkg::F_LEN : sha1s_pkg::F_ZERO;
        end
      end
      sha1s_pkg::F_LEN: begin
        if (wr_ok && len_idx_r == sha1s_pkg::LAST_LEN) state_nxt = sha1s_pkg::F_IDLE;
      end
      default: begin
        state_nxt = sha1s_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1s_pkg::F_IDLE;
      fill_r    <= '0;
      total_r   <= '0;
      len_idx_r <= '0;
      bidx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        bidx_r <= '0;
      end else if (wr_ok && state_r == sha1s_pkg::F_DATA) begin
        bidx_r <= bidx_r + 2'd1;
      end
      if (wr_ok) begin
        fill_r <= fill_inc;
      end
      if (wr_ok && state_r == sha1s_pkg::F_DATA) begin
        total_r <= total_r + 64'd1;
      end else if (wr_ok && state_r == sha1s_pkg::F_LEN && len_idx_r == sha1s_pkg::LAST_LEN) begin
        total_r <= '0;
      end
      if (wr_ok && state_r == sha1s_pkg::F_LEN) begin
        len_idx_r <= len_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_word_r <= in_item.message_word;
      cnt_r       <= cnt_sat;
      end_r       <= in_item.end_of_message;
    end
    if (wr_ok) begin
      blk_r <= blk_wr;
    end
  end

  a_len_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1s_pkg::F_LEN |-> fill_r >= sha1s_pkg::LEN_POS)
    else $error("length bytes outside the block tail");

  a_len_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ok && state_r == sha1s_pkg::F_LEN && len_idx_r == sha1s_pkg::LAST_LEN) |-> push)
    else $error("last length byte did not complete a block");

endmodule

/* design/sha1s_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_queue
// Short block queue between the byte packer and the compression engine.
// ----------------------------------------------------------------------------
module sha1s_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sha1s_pkg::blk_entry_t push_entry,
  input  logic                  pop,
  output sha1s_pkg::blk_entry_t head,
  output sha1s_pkg::q_stat_t    q_stat
);

  sha1s_pkg::blk_entry_t mem_r [sha1s_pkg::Q_DEPTH];

  logic [sha1s_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [sha1s_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [sha1s_pkg::Q_CNT_W-1:0] count_r;

  assign q_stat.full  = (count_r == sha1s_pkg::Q_CNT_W'(sha1s_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sha1s_pkg::Q_PTR_W'(sha1s_pkg::Q_DEPTH - 1)) ? '0
                                                                               : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sha1s_pkg::Q_PTR_W'(sha1s_pkg::Q_DEPTH - 1)) ? '0
                                                                               : rd_ptr_r + 1'b1;
      end
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full && !pop) && !(pop && q_stat.empty))
    else $error("block queue overflow or underflow");

endmodule

/* design/sha1s_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_core
// SHA-1 compression engine: one round per cycle with a rolling 16-word
// schedule, chaining update, and digest output through a result register.
// ----------------------------------------------------------------------------
module sha1s_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1s_pkg::q_stat_t    q_stat,
  input  sha1s_pkg::blk_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1s_pkg::out_item_t  out_item
);

  sha1s_pkg::core_state_t state_r, state_nxt;

  logic [6:0]                                       rnd_r;
  logic [sha1s_pkg::BLK_WORDS-1:0][31:0]            w_r;
  logic [31:0]                                      a_r, b_r, c_r, d_r, e_r;
  logic [sha1s_pkg::DIGEST_WORDS-1:0][31:0]         chain_r;
  logic                                             last_r;
  logic [2:0]                                       oidx_r;
  logic                                             out_valid_r;
  sha1s_pkg::out_item_t                             out_item_r;

  logic        slot_free;
  logic        load_out;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] t_sum;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1s_pkg::round_f(rnd_r, b_r, c_r, d_r)
               + e_r + w_r[0] + sha1s_pkg::round_k(rnd_r);

  // outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      sha1s_pkg::C_IDLE:  pop      = !q_stat.empty;
      sha1s_pkg::C_OUT:   load_out = slot_free;
      default:            pop      = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1s_pkg::C_IDLE: begin
        if (!q_stat.empty) state_nxt = sha1s_pkg::C_ROUND;
      end
      sha1s_pkg::C_ROUND: begin
        if (rnd_r == sha1s_pkg::LAST_RND) state_nxt = sha1s_pkg::C_ADD;
      end
      sha1s_pkg::C_ADD: begin
        state_nxt = last_r ? sha1s_pkg::C_OUT : sha1s_pkg::C_IDLE;
      end
      sha1s_pkg::C_OUT: begin
        if (slot_free && oidx_r == sha1s_pkg::LAST_IDX) state_nxt = sha1s_pkg::C_IDLE;
      end
      default: begin
        state_nxt = sha1s_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1s_pkg::C_IDLE;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      for (int i = 0; i < sha1s_pkg::DIGEST_WORDS; i++) begin
        chain_r[i] <= sha1s_pkg::init_h(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        rnd_r <= '0;
      end else if (state_r == sha1s_pkg::C_ROUND) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (state_r == sha1s_pkg::C_ADD) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
        oidx_r     <= '0;
      end else if (load_out) begin
        oidx_r <= oidx_r + 3'd1;
        // start the next message from the initial hash once the last word leaves
        if (oidx_r == sha1s_pkg::LAST_IDX) begin
          for (int i = 0; i < sha1s_pkg::DIGEST_WORDS; i++) begin
            chain_r[i] <= sha1s_pkg::init_h(3'(i));
          end
        end
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < sha1s_pkg::BLK_WORDS; i++) begin
        w_r[i] <= head.block[sha1s_pkg::BLK_BITS - 32 * (i + 1) +: 32];
      end
      a_r    <= chain_r[0];
      b_r    <= chain_r[1];
      c_r    <= chain_r[2];
      d_r    <= chain_r[3];
      e_r    <= chain_r[4];
      last_r <= head.last_blk;
    end else if (state_r == sha1s_pkg::C_ROUND) begin
      for (int i = 0; i < sha1s_pkg::BLK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[sha1s_pkg::BLK_WORDS - 1] <= w_new;
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t_sum;
    end
    if (load_out) begin
      out_item_r.digest_word <= chain_r[oidx_r];
      out_item_r.word_index  <= oidx_r;
      out_item_r.last_word   <= (oidx_r == sha1s_pkg::LAST_IDX);
    end
  end

  a_pop_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == sha1s_pkg::C_ROUND && rnd_r == 7'd0))
    else $error("block taken without starting the rounds");

  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1s_pkg::C_OUT |-> last_r)
    else $error("digest output after a non-final block");

  a_last_word_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_word) |-> out_item_r.word_index == sha1s_pkg::LAST_IDX)
    else $error("last digest word with wrong index");

endmodule

/* design/sha1_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// Streaming SHA-1: byte packer, block queue and round engine.
// ----------------------------------------------------------------------------
// Input: a word is taken only while the packer is idle; its N valid bytes then go in
//   one per cycle, a block's last byte waiting while the queue is full. Engine: load,
//   80 rounds at one per cycle, add per 64-byte block, overlapped with packing of
//   the next block through a two-block queue; full-word throughput is set by the round engine.
// Final word: up to 72 pad/length bytes in one or two blocks, one per cycle unless
//   the queue is full, then five digest items, one per cycle while out_ready is high.
// Reset (synchronous, rst_n low) clears all control and loads the initial hash.
module sha1_stream_hasher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha1s_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha1s_pkg::out_item_t out_item
);

  logic                  push;
  logic                  pop;
  sha1s_pkg::blk_entry_t push_entry;
  sha1s_pkg::blk_entry_t head;
  sha1s_pkg::q_stat_t    q_stat;

  sha1s_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  sha1s_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sha1s_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* dv/tb_sha1_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher_unit
// Drives byte-packed message words into the streaming SHA-1 hasher and checks
// every digest item against a bit-accurate bench hash or a typed-in digest.
// A short table of directed words comes first, then random messages of mixed
// length and alignment, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher_unit;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 6;
  localparam int DIR_ROWS    = 14;
  localparam int RAND_ITEMS  = 366;
  localparam int STUCK_LIMIT = 5000;
  localparam int TAIL_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    RX_FREE,
    RX_PATTERN,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_t;

  typedef struct packed {
    sha1s_pkg::in_item_t item;
    logic                known;
    logic [159:0]        digest;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  sha1s_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sha1s_pkg::out_item_t out_item;

  sha1_stream_hasher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #CLK_HALF clk = ~clk;

  // Stimulus, with a typed-in digest for the rows that carry one.
  dir_row_t             dir_rows [DIR_ROWS];
  sha1s_pkg::in_item_t  stim_q [$];
  bit                   known_q [$];
  logic [159:0]         known_digest_q [$];

  sha1s_pkg::out_item_t pending_digest_q [$];

  int unsigned  next_idx     = 0;
  int unsigned  fed_cnt      = 0;
  int unsigned  burst_left   = 1;
  int unsigned  gap_left     = 0;
  int unsigned  err_cnt      = 0;
  int unsigned  stuck_cycles = 0;

  // Software hash state.
  logic [31:0]  chain_h [5];
  logic [31:0]  blk_w [16];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_bytes;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic chain_restart();
    chain_h[0] = sha1s_pkg::H0;
    chain_h[1] = sha1s_pkg::H1;
    chain_h[2] = sha1s_pkg::H2;
    chain_h[3] = sha1s_pkg::H3;
    chain_h[4] = sha1s_pkg::H4;
    blk_fill   = '0;
    msg_bytes  = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk_w[i];
    for (i = 16; i < 80; i++) w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1s_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1s_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1s_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1s_pkg::K3;
      end
      t = rotl32(a, 5) + f + e + w[i] + k;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic put_byte(input logic [7:0] b);
    blk_w[blk_fill[5:2]][(3 - blk_fill[1:0]) * 8 +: 8] = b;
    if (blk_fill == sha1s_pkg::LAST_POS) compress_block();
    blk_fill = blk_fill + 6'd1;
  endtask

  // Absorb one word; on the final word pad, finish and return the digest.
  task automatic hash_word(input sha1s_pkg::in_item_t it, output bit done,
                           output logic [159:0] dg);
    int unsigned n;
    int i;
    logic [63:0] bit_len;
    n = (it.byte_count > sha1s_pkg::MAX_BYTES) ? sha1s_pkg::MAX_BYTES : it.byte_count;
    for (i = 0; i < n; i++) begin
      put_byte(it.message_word[31 - 8 * i -: 8]);
      msg_bytes = msg_bytes + 64'd1;
    end
    done = it.end_of_message;
    dg   = '0;
    if (done) begin
      bit_len = msg_bytes << 3;
      put_byte(sha1s_pkg::PAD_BYTE);
      while (blk_fill != sha1s_pkg::LEN_POS) put_byte(8'h00);
      for (i = 0; i < 8; i++) put_byte(bit_len[63 - 8 * i -: 8]);
      dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
      chain_restart();
    end
  endtask

  // Sender: bursts of items with random gaps; predict on every accepted item.
  always @(posedge clk) begin : feed
    bit                   msg_done;
    logic [159:0]         msg_digest;
    sha1s_pkg::out_item_t want;
    int                   j;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_word(in_item, msg_done, msg_digest);
        if (msg_done) begin
          if (known_q[fed_cnt]) msg_digest = known_digest_q[fed_cnt];
          for (j = 0; j < sha1s_pkg::DIGEST_WORDS; j++) begin
            want.digest_word = msg_digest[159 - 32 * j -: 32];
            want.word_index  = j[2:0];
            want.last_word   = (j[2:0] == sha1s_pkg::LAST_IDX);
            pending_digest_q.push_back(want);
          end
        end
        fed_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (next_idx < stim_q.size()) begin
          in_valid <= 1'b1;
          in_item  <= stim_q[next_idx];
          next_idx++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between stall modes at random intervals.
  rx_mode_t    rx_mode      = RX_FREE;
  int unsigned rx_mode_left = 0;
  logic [12:0] stall_pat    = 13'b1011001110001;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(32, 256);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      stall_pat <= {stall_pat[11:0], stall_pat[12]};
      case (rx_mode)
        RX_FREE:    out_ready <= 1'b1;
        RX_PATTERN: out_ready <= stall_pat[0];
        RX_SPARSE:  out_ready <= ($urandom_range(0, 9) < 3);
        default:    out_ready <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Compare each digest item with the oldest one waiting.
  always @(posedge clk) begin : check
    sha1s_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected digest item: word %h index %0d last %0b",
                   $realtime, out_item.digest_word, out_item.word_index, out_item.last_word);
      end else begin
        want = pending_digest_q.pop_front();
        if (out_item.digest_word !== want.digest_word ||
            out_item.word_index !== want.word_index ||
            out_item.last_word !== want.last_word) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display({"%0t: digest mismatch: expected word %h index %0d last %0b,",
                      " got word %h index %0d last %0b"},
                     $realtime, want.digest_word, want.word_index, want.last_word,
                     out_item.digest_word, out_item.word_index, out_item.last_word);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : run
    sha1s_pkg::in_item_t it;
    int unsigned         n_words;
    int                  r, i;
    chain_restart();
    for (i = 0; i < 16; i++) blk_w[i] = '0;

    // Directed words; a digest is typed in only for textbook messages.
    dir_rows[0]  = '{'{32'h00000000, 3'd0, 1'b1}, 1'b1,
                     160'hda39a3ee5e6b4b0d3255bfef95601890afd80709};
    dir_rows[1]  = '{'{32'h61626300, 3'd3, 1'b1}, 1'b1,
                     160'ha9993e364706816aba3e25717850c26c9cd0d89d};
    dir_rows[2]  = '{'{32'h61000000, 3'd1, 1'b1}, 1'b1,
                     160'h86f7e437faa5a7fce15d1ddcb9eaeaea377667b8};
    // Zero byte count on the final word ignores the word: empty message.
    dir_rows[3]  = '{'{32'hffffffff, 3'd0, 1'b1}, 1'b1,
                     160'hda39a3ee5e6b4b0d3255bfef95601890afd80709};
    dir_rows[4]  = '{'{32'hffffffff, 3'd7, 1'b1}, 1'b0, 160'h0};
    dir_rows[5]  = '{'{32'hffffffff, 3'd4, 1'b0}, 1'b0, 160'h0};
    dir_rows[6]  = '{'{32'h00000000, 3'd4, 1'b0}, 1'b0, 160'h0};
    dir_rows[7]  = '{'{32'ha5a5a5a5, 3'd1, 1'b0}, 1'b0, 160'h0};
    dir_rows[8]  = '{'{32'h5a5a5a5a, 3'd2, 1'b0}, 1'b0, 160'h0};
    dir_rows[9]  = '{'{32'h12345678, 3'd0, 1'b0}, 1'b0, 160'h0};
    dir_rows[10] = '{'{32'h87654321, 3'd5, 1'b0}, 1'b0, 160'h0};
    dir_rows[11] = '{'{32'hdeadbeef, 3'd6, 1'b0}, 1'b0, 160'h0};
    dir_rows[12] = '{'{32'hcafef00d, 3'd3, 1'b1}, 1'b0, 160'h0};
    dir_rows[13] = '{'{32'h00000000, 3'd4, 1'b1}, 1'b0, 160'h0};

    for (r = 0; r < DIR_ROWS; r++) begin
      stim_q.push_back(dir_rows[r].item);
      known_q.push_back(dir_rows[r].known);
      known_digest_q.push_back(dir_rows[r].digest);
    end

    // Random messages: mostly short, some across two blocks, a few long.
    while (stim_q.size() < DIR_ROWS + RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       n_words = $urandom_range(40, 70);
        1, 2, 3: n_words = $urandom_range(12, 34);
        default: n_words = $urandom_range(0, 18);
      endcase
      for (i = 0; i <= n_words; i++) begin
        case ($urandom_range(0, 9))
          0:       it.message_word = '0;
          1:       it.message_word = '1;
          default: it.message_word = $urandom;
        endcase
        it.end_of_message = (i == n_words);
        if (it.end_of_message || $urandom_range(0, 99) < 12)
          it.byte_count = 3'($urandom_range(0, 7));
        else it.byte_count = sha1s_pkg::MAX_BYTES;
        stim_q.push_back(it);
        known_q.push_back(1'b0);
        known_digest_q.push_back('0);
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (!(fed_cnt == stim_q.size() && pending_digest_q.size() == 0) &&
           stuck_cycles < STUCK_LIMIT)
      @(posedge clk);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("** sha1_stream_hasher_unit: FAILED **");
    end else begin
      // Hold for stray items after the last digest.
      repeat (TAIL_CYCLES) @(posedge clk);
      if (err_cnt == 0) begin
        $display("** sha1_stream_hasher_unit: PASSED **");
      end else begin
        $display("** sha1_stream_hasher_unit: FAILED **");
      end
    end
    $finish;
  end

endmodule
